// ===== design/mcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbd_pkg: shared definitions for the mip chain box downsampler
// Field widths, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
package mcbd_pkg;

   // Widths of the configuration registers and of the per-level counters.
   localparam int CFG_W   = 13;
   localparam int CNT_W   = 12;
   localparam int CH_W    = 8;
   localparam int PAIR_W  = 9;
   localparam int PIX_W   = 4 * CH_W;
   localparam int PAIRS_W = 4 * PAIR_W;
   localparam int LVL_W   = 4;
   localparam int POS_W   = 11;
   localparam int IDX_W   = 2;

   // Largest base height that the frame counters follow.
   localparam int MAX_HEIGHT = 4096;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOOK = 3'b010,
      S_SUM  = 3'b100
   } state_type;

endpackage

// ===== design/mcbd_ram.sv =====
// ----------------------------------------------------------------------------
// mcbd_ram: generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcbd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mipmap_chain_box_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// mipmap_chain_box_downsampler_top: streaming mip chain generator
// Base RGBA pixels in raster order; every pixel of levels 1 and up leaves as
// soon as its 2x2 source block is complete, built from a 2x2 box filter.
// ----------------------------------------------------------------------------
// Output: the first result of a pixel is loaded into the output register in the sum
// state, after the lookup state that issues the line store read; a stalled result holds the sum state.
// Flow: a new pixel is accepted only in the idle state; each pixel passes an accept
// step, one lookup per level visited and one sum per result made, plus result
// stalls; all levels run through the shared level sequencer.
// Reset: synchronous; counters clear, width and height return to 4096.
module mipmap_chain_box_downsampler_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_LEVELS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration port
   input  logic                            csr_write,
   input  logic [mcbd_pkg::IDX_W-1:0]      csr_index,
   input  logic [mcbd_pkg::CFG_W-1:0]      csr_data,
   // Pixel input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mcbd_pkg::CH_W-1:0]       req_red,
   input  logic [mcbd_pkg::CH_W-1:0]       req_green,
   input  logic [mcbd_pkg::CH_W-1:0]       req_blue,
   input  logic [mcbd_pkg::CH_W-1:0]       req_alpha,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mcbd_pkg::LVL_W-1:0]      rsp_level,
   output logic [mcbd_pkg::POS_W-1:0]      rsp_col,
   output logic [mcbd_pkg::POS_W-1:0]      rsp_row,
   output logic [mcbd_pkg::CH_W-1:0]       rsp_out_red,
   output logic [mcbd_pkg::CH_W-1:0]       rsp_out_green,
   output logic [mcbd_pkg::CH_W-1:0]       rsp_out_blue,
   output logic [mcbd_pkg::CH_W-1:0]       rsp_out_alpha,
   output logic                            rsp_last
);

   import mcbd_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int KW = $clog2(MAX_LEVELS + 1);
   localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   // Level pixel decision for one level: whether this pixel writes the hold
   // register, writes the line store or completes a 2x2 block.
   typedef struct packed {
      logic hold_wr;
      logic line_wr;
      logic made;
   } lvl_act_type;

   function automatic lvl_act_type lvl_action(input logic [CFG_W-1:0] wk,
                                              input logic [CFG_W-1:0] hk,
                                              input logic [CNT_W-1:0] x,
                                              input logic [CNT_W-1:0] y);
      lvl_act_type a;
      logic        use_px;
      use_px = (wk > 13'd1) && (hk > 13'd1) &&
               ({1'b0, x} < {wk[CFG_W-1:1], 1'b0}) &&
               ({1'b0, y} < {hk[CFG_W-1:1], 1'b0});
      a.hold_wr = use_px && !x[0];
      a.line_wr = use_px && x[0] && !y[0];
      a.made    = use_px && x[0] && y[0];
      return a;
   endfunction

   // Line store address: start of the region of a level plus the pair column.
   function automatic logic [AW-1:0] line_addr(input logic [KW-1:0] k,
                                               input logic [CNT_W-1:0] x);
      logic [31:0] a;
      a = 32'(MAX_WIDTH) - (32'(MAX_WIDTH) >> k) + 32'(x[CNT_W-1:1]);
      return a[AW-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [CFG_W-1:0] eff_w, eff_h, wk, hk, wk_nx, hk_nx;
   logic [KW-1:0]    lvl_ff, lvl_in, lvl_nx;
   logic [IW-1:0]    cur_i, nxt_i;
   logic             nxt_ok;
   logic [CNT_W-1:0] colcnt_ff [MAX_LEVELS];
   logic [CNT_W-1:0] rowcnt_ff [MAX_LEVELS];
   logic [PIX_W-1:0] hold_ff [MAX_LEVELS];
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [POS_W-1:0] look_col_ff, look_row_ff;
   logic             fend_ff, fend_in;
   logic [CFG_W-1:0] x_inc, y_inc;
   logic [CNT_W-1:0] x_next, y_next;
   lvl_act_type      act_cur, act_nxt;
   logic [AW-1:0]    addr;
   logic [PAIRS_W-1:0] pair_wdata, pair_rdata;
   logic [PIX_W-1:0] avg_pix;
   logic             ram_wr, ram_rd;
   logic             out_load, finish;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0] out_level_ff;
   logic [POS_W-1:0] out_col_ff, out_row_ff;
   logic [PIX_W-1:0] out_pix_ff;
   logic             out_last_ff;

   // Effective frame size after clamping.
   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = 13'd1;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = CFG_W'(MAX_WIDTH);
      end
      eff_h = height_ff;
      if (height_ff == '0) begin
         eff_h = 13'd1;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = CFG_W'(MAX_HEIGHT);
      end
   end

   // Current and next level indexes and their dimensions.
   always_comb begin
      cur_i  = lvl_ff[IW-1:0];
      lvl_nx = lvl_ff + 1'b1;
      nxt_ok = (lvl_nx < KW'(MAX_LEVELS));
      nxt_i  = nxt_ok ? lvl_nx[IW-1:0] : cur_i;
      wk     = eff_w >> lvl_ff;
      hk     = eff_h >> lvl_ff;
      wk_nx  = eff_w >> lvl_nx;
      hk_nx  = eff_h >> lvl_nx;
      act_cur = lvl_action(wk, hk, colcnt_ff[cur_i], rowcnt_ff[cur_i]);
      act_nxt = lvl_action(wk_nx, hk_nx, colcnt_ff[nxt_i], rowcnt_ff[nxt_i]);
      act_nxt.made = act_nxt.made && nxt_ok;
   end

   // Counter advance for the current level, wrapping at the level size.
   always_comb begin
      x_inc = {1'b0, colcnt_ff[cur_i]} + 13'd1;
      y_inc = {1'b0, rowcnt_ff[cur_i]};
      if (x_inc >= wk) begin
         x_inc = '0;
         y_inc = y_inc + 13'd1;
         if (y_inc >= hk) begin
            y_inc = '0;
         end
      end
      x_next = x_inc[CNT_W-1:0];
      y_next = y_inc[CNT_W-1:0];
   end

   // Line store access: pair sums on even rows, reads on odd rows.
   always_comb begin
      addr   = line_addr(lvl_ff, colcnt_ff[cur_i]);
      ram_wr = (state_ff == S_LOOK) && act_cur.line_wr;
      ram_rd = (state_ff == S_LOOK) && act_cur.made;
      for (int c = 0; c < 4; c++) begin
         pair_wdata[c*PAIR_W +: PAIR_W] = {1'b0, hold_ff[cur_i][c*CH_W +: CH_W]} +
                                          {1'b0, pix_ff[c*CH_W +: CH_W]};
      end
   end

   mcbd_ram #(
      .WIDTH (PAIRS_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr),
      .wr_data (pair_wdata),
      .rd_en   (ram_rd),
      .rd_addr (addr),
      .rd_data (pair_rdata)
   );

   // Box filter: stored pair sum plus the held left pixel plus this pixel.
   always_comb begin
      logic [PAIR_W:0] tot;
      for (int c = 0; c < 4; c++) begin
         tot = {1'b0, pair_rdata[c*PAIR_W +: PAIR_W]} +
               {2'b0, hold_ff[cur_i][c*CH_W +: CH_W]} +
               {2'b0, pix_ff[c*CH_W +: CH_W]};
         avg_pix[c*CH_W +: CH_W] = tot[PAIR_W:2];
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      pix_in       = pix_ff;
      fend_in      = fend_ff;
      out_load     = 1'b0;
      finish       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
               lvl_in   = '0;
               pix_in   = {req_alpha, req_blue, req_green, req_red};
               fend_in  = ({1'b0, colcnt_ff[0]} == eff_w - 13'd1) &&
                          ({1'b0, rowcnt_ff[0]} == eff_h - 13'd1);
            end
         end
         S_LOOK: begin
            if (act_cur.made) begin
               state_in = S_SUM;
            end else begin
               state_in = S_IDLE;
               finish   = 1'b1;
            end
         end
         S_SUM: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               pix_in       = avg_pix;
               if (nxt_ok) begin
                  state_in = S_LOOK;
                  lvl_in   = lvl_nx;
               end else begin
                  state_in = S_IDLE;
                  finish   = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         fend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 13'd4096;
         height_ff    <= 13'd4096;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         fend_ff      <= fend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_write && csr_index == REG_IMAGE_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

   // Per-level position counters; cleared by reset, by a width or height write and at frame end.
   always_ff @(posedge clock) begin
      if (reset || (csr_write && (csr_index == REG_IMAGE_WIDTH ||
                                  csr_index == REG_IMAGE_HEIGHT)) ||
          (finish && fend_ff)) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            colcnt_ff[i] <= '0;
            rowcnt_ff[i] <= '0;
         end
      end else if (state_ff == S_LOOK) begin
         colcnt_ff[cur_i] <= x_next;
         rowcnt_ff[cur_i] <= y_next;
      end
   end

   // Pixel datapath registers; the block position is kept before the counters move.
   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      if (state_ff == S_LOOK) begin
         look_col_ff <= colcnt_ff[cur_i][CNT_W-1:1];
         look_row_ff <= rowcnt_ff[cur_i][CNT_W-1:1];
      end
      if ((state_ff == S_LOOK) && act_cur.hold_wr) begin
         hold_ff[cur_i] <= pix_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_level_ff <= LVL_W'(lvl_ff) + 4'd1;
         out_col_ff   <= look_col_ff;
         out_row_ff   <= look_row_ff;
         out_pix_ff   <= avg_pix;
         out_last_ff  <= !act_nxt.made;
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = out_level_ff;
   assign rsp_col       = out_col_ff;
   assign rsp_row       = out_row_ff;
   assign rsp_out_red   = out_pix_ff[0*CH_W +: CH_W];
   assign rsp_out_green = out_pix_ff[1*CH_W +: CH_W];
   assign rsp_out_blue  = out_pix_ff[2*CH_W +: CH_W];
   assign rsp_out_alpha = out_pix_ff[3*CH_W +: CH_W];
   assign rsp_last      = out_last_ff;

   // A sum cycle always follows the lookup that issued its line store read.
   a_sum_after_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && !$past(state_ff == S_SUM)) |-> $past(state_ff == S_LOOK))
      else $error("sum state entered without a line store read");

   // A pixel transfer starts the level walk.
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_LOOK && lvl_ff == '0))
      else $error("accepted pixel did not start at level zero");

   // Emitted levels stay within the chain.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level >= 4'd1 && 32'(rsp_level) <= MAX_LEVELS))
      else $error("result level out of range");

   // The base counters stay inside the frame.
   a_base_pos: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, colcnt_ff[0]} < eff_w) && ({1'b0, rowcnt_ff[0]} < eff_h))
      else $error("base position outside the frame");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for mipmap_chain_box_downsampler_top
// A scoreboard class predicts every mip texel from each accepted base pixel
// and compares the texels that leave the block, in order, field by field.
// The stimulus covers directed frames, random frame sizes, oversized bases,
// and a deep cascade, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
   import mcbd_pkg::*;

   localparam int LINE_DEPTH    = 4096;
   localparam int LEVELS        = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 160;
   localparam int REPORT_LIMIT  = 10;

   // Register indexes that map to nothing; writes to them are dropped.
   localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
   localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic [CH_W-1:0]  alpha;
      logic             last;
   } mip_texel_type;

   function automatic string texel_text(mip_texel_type t);
      return $sformatf("level %0d col %0d row %0d rgba %0d %0d %0d %0d last %0d",
                       t.level, t.col, t.row, t.red, t.green, t.blue, t.alpha, t.last);
   endfunction

   // Scoreboard: mirrors the level counters, hold pixels and pair-sum lines.
   class mip_chain_scoreboard;
      logic [CFG_W-1:0]  width_reg;
      logic [CFG_W-1:0]  height_reg;
      bit   [PAIR_W-1:0] pair_sum [LINE_DEPTH][4];
      bit   [CH_W-1:0]   left_hold [LEVELS+1][4];
      bit   [CNT_W-1:0]  col_cnt [LEVELS+1];
      bit   [CNT_W-1:0]  row_cnt [LEVELS+1];
      mip_texel_type     pending_texels[$];
      int                failures;

      function new();
         width_reg  = 13'd4096;
         height_reg = 13'd4096;
         failures   = 0;
         clear_counters();
      endfunction

      function void clear_counters();
         for (int i = 0; i <= LEVELS; i++) begin
            col_cnt[i] = '0;
            row_cnt[i] = '0;
         end
      endfunction

      function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned top);
         if (v == 0) return 1;
         if (v > top) return top;
         return v;
      endfunction

      // A write to a mapped register restarts the frame at the next pixel.
      function void apply_reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         if (idx == REG_IMAGE_WIDTH) begin
            width_reg = value;
            clear_counters();
         end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = value;
            clear_counters();
         end
      endfunction

      // Walk the levels for one base pixel; each new texel feeds the next level.
      function void note_pixel(logic [CH_W-1:0] r, g, b, a);
         int unsigned   w, h, wk, hk, x, y, k, idx;
         int unsigned   cur[4];
         int unsigned   nxt[4];
         bit            made, frame_end;
         int            made_count;
         mip_texel_type t;
         w = clamp_dim(width_reg, LINE_DEPTH);
         h = clamp_dim(height_reg, MAX_HEIGHT);
         cur[0] = r;
         cur[1] = g;
         cur[2] = b;
         cur[3] = a;
         frame_end = (col_cnt[0] == w - 1) && (row_cnt[0] == h - 1);
         made_count = 0;
         k = 0;
         do begin
            wk = w >> k;
            hk = h >> k;
            x = col_cnt[k];
            y = row_cnt[k];
            made = 1'b0;
            // Odd last column and row of a level are dropped.
            if (k < LEVELS && wk > 1 && hk > 1 && x < (wk & ~1) && y < (hk & ~1)) begin
               if ((x & 1) == 0) begin
                  for (int c = 0; c < 4; c++) left_hold[k][c] = CH_W'(cur[c]);
               end else begin
                  idx = LINE_DEPTH - (LINE_DEPTH >> k) + (x >> 1);
                  if ((y & 1) == 0) begin
                     for (int c = 0; c < 4; c++)
                        pair_sum[idx][c] = PAIR_W'(left_hold[k][c] + cur[c]);
                  end else begin
                     for (int c = 0; c < 4; c++)
                        nxt[c] = (int'(pair_sum[idx][c]) + left_hold[k][c] + cur[c]) >> 2;
                     t.level = LVL_W'(k + 1);
                     t.col   = POS_W'(x >> 1);
                     t.row   = POS_W'(y >> 1);
                     t.red   = CH_W'(nxt[0]);
                     t.green = CH_W'(nxt[1]);
                     t.blue  = CH_W'(nxt[2]);
                     t.alpha = CH_W'(nxt[3]);
                     t.last  = 1'b0;
                     pending_texels.push_back(t);
                     made_count++;
                     made = 1'b1;
                  end
               end
            end
            x++;
            if (x >= wk) begin
               x = 0;
               y++;
               if (y >= hk) y = 0;
            end
            col_cnt[k] = CNT_W'(x);
            row_cnt[k] = CNT_W'(y);
            cur = nxt;
            k++;
         end while (made && k <= LEVELS);
         if (frame_end) clear_counters();
         // The final texel caused by this pixel carries the last flag.
         if (made_count > 0) begin
            t = pending_texels.pop_back();
            t.last = 1'b1;
            pending_texels.push_back(t);
         end
      endfunction

      function void check_texel(mip_texel_type got);
         mip_texel_type want;
         if (pending_texels.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: unexpected texel: %s", texel_text(got));
            return;
         end
         want = pending_texels.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("ERROR: texel mismatch at %0t", $realtime);
               $display("  expected %s", texel_text(want));
               $display("  actual   %s", texel_text(got));
            end
         end
      endfunction
   endclass

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               csr_write     = 1'b0;
   logic [IDX_W-1:0]   csr_index     = '0;
   logic [CFG_W-1:0]   csr_data      = '0;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [CH_W-1:0]    req_red       = '0;
   logic [CH_W-1:0]    req_green     = '0;
   logic [CH_W-1:0]    req_blue      = '0;
   logic [CH_W-1:0]    req_alpha     = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic [LVL_W-1:0]   rsp_level;
   logic [POS_W-1:0]   rsp_col;
   logic [POS_W-1:0]   rsp_row;
   logic [CH_W-1:0]    rsp_out_red;
   logic [CH_W-1:0]    rsp_out_green;
   logic [CH_W-1:0]    rsp_out_blue;
   logic [CH_W-1:0]    rsp_out_alpha;
   logic               rsp_last;

   mip_chain_scoreboard sb = new();
   int                  stall_span = 0;

   mipmap_chain_box_downsampler_top #(
      .MAX_WIDTH  (LINE_DEPTH),
      .MAX_LEVELS (LEVELS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_alpha     (req_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_col       (rsp_col),
      .rsp_row       (rsp_row),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // Sink stall pattern: long free stretches, short stalls, short free runs.
   always @(posedge clock) begin
      if (stall_span > 0) begin
         stall_span <= stall_span - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: begin
               rsp_stall  <= 1'b0;
               stall_span <= $urandom_range(50, 200);
            end
            2, 3, 4, 5: begin
               rsp_stall  <= 1'b1;
               stall_span <= $urandom_range(0, 3);
            end
            default: begin
               rsp_stall  <= 1'b0;
               stall_span <= $urandom_range(0, 7);
            end
         endcase
      end
   end

   // Sample every register write and every transfer on both channels.
   always @(posedge clock) begin : watch_ports
      mip_texel_type seen;
      if (!reset) begin
         if (csr_write) sb.apply_reg_write(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_pixel(req_red, req_green, req_blue, req_alpha);
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_level, rsp_col, rsp_row, rsp_out_red, rsp_out_green,
                    rsp_out_blue, rsp_out_alpha, rsp_last};
            sb.check_texel(seen);
         end
      end
   end

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      write_csr(REG_IMAGE_WIDTH, w);
      write_csr(REG_IMAGE_HEIGHT, h);
   endtask

   // Hold one pixel on the input until its transfer; valid stays high.
   task automatic send_pixel(input logic [CH_W-1:0] r, g, b, a);
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      req_alpha <= a;
      do @(posedge clock); while (req_stall);
   endtask

   // Stream random pixels in bursts; drain_at forces a full drain after that pixel.
   task automatic stream_pixels(input int count, input int drain_at);
      int              burst;
      logic [CH_W-1:0] ch[4];
      burst = $urandom_range(1, 20);
      for (int i = 0; i < count; i++) begin
         for (int c = 0; c < 4; c++)
            ch[c] = ($urandom_range(0, 7) == 0) ?
                    ($urandom_range(0, 1) ? {CH_W{1'b1}} : {CH_W{1'b0}}) :
                    CH_W'($urandom_range(0, 255));
         send_pixel(ch[0], ch[1], ch[2], ch[3]);
         burst--;
         if (i < count - 1) begin
            if (i == drain_at || (burst <= 0 && $urandom_range(0, 11) == 0)) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (sb.pending_texels.size() != 0) @(posedge clock);
               burst = $urandom_range(1, 20);
            end else if (burst <= 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
               burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                     $urandom_range(1, 20);
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every expected texel, then let a pixel still in flight finish.
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_texels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int w, h, count, random_items;
      random_items = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default 4096 x 4096 base: the first row completes no block.
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
      send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
      drain_and_idle();

      // 2x2 base: extreme channels and truncation of the block sum.
      configure(13'd2, 13'd2);
      send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
      send_pixel(8'hFE, 8'h00, 8'h01, 8'h00);
      drain_and_idle();

      // Zero width and height act as 1x1: every pixel ends a frame.
      configure(13'd0, 13'd0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      drain_and_idle();

      // 4x4 base split by writes to unmapped indexes, which keep the frame going.
      configure(13'd4, 13'd4);
      stream_pixels(8, -1);
      drain_and_idle();
      write_csr(REG_UNMAPPED_LO, 13'd3);
      write_csr(REG_UNMAPPED_HI, 13'd1);
      stream_pixels(8, -1);
      drain_and_idle();

      // Random frame sizes; some frames are cut short by the next setting.
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: begin
               w = $urandom_range(1, 3);
               h = $urandom_range(1, 40);
            end
            1: begin
               w = $urandom_range(1, 40);
               h = $urandom_range(1, 3);
            end
            2: begin
               w = $urandom_range(9, 24);
               h = $urandom_range(9, 24);
            end
            default: begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 8);
            end
         endcase
         if ($urandom_range(0, 3) == 0)
            count = $urandom_range(1, w * h);
         else
            count = w * h * ((w * h > 100) ? 1 : $urandom_range(1, 3));
         if (count > RANDOM_ITEMS - random_items)
            count = RANDOM_ITEMS - random_items;
         configure(CFG_W'(w), CFG_W'(h));
         stream_pixels(count, -1);
         drain_and_idle();
         random_items += count;
      end

      // Oversized width acts as 4096: the first row completes no block.
      configure(13'd8191, 13'd2);
      stream_pixels(24, -1);
      drain_and_idle();

      // Oversized height acts as 4096: two columns give one texel per two rows.
      configure(13'd2, 13'd8191);
      stream_pixels(24, -1);
      drain_and_idle();

      // 16x16 base cascades down to a single texel; the source pauses midway.
      configure(13'd16, 13'd16);
      stream_pixels(16 * 16, 128);
      drain_and_idle();

      if (sb.failures == 0 && sb.pending_texels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
